[hw/rtl/expiry_ordered_timer_queue_unit_defines.svh]
// Assertion macros for the expiry ordered timer queue.
// Used by the top level; expects clk and rst_n in scope.
`ifndef EXPIRY_ORDERED_TIMER_QUEUE_UNIT_DEFINES_SVH
`define EXPIRY_ORDERED_TIMER_QUEUE_UNIT_DEFINES_SVH

// prop must hold at every clock edge outside reset
`define EOTQ_CHECK(name, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("eotq check failed");

// expr must never be true outside reset
`define EOTQ_NEVER(name, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("eotq forbidden condition");

`endif

[hw/rtl/eotq_pkg.sv]
// Shared types and constants for the expiry ordered timer queue.
// No dependencies.
package eotq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int MAX_RESULTS     = 16;
    localparam int CNT_W           = $clog2(MAX_RESULTS + 1);

    localparam logic [1:0] ST_RELEASED = 2'd0;
    localparam logic [1:0] ST_ACCEPTED = 2'd1;
    localparam logic [1:0] ST_DROPPED  = 2'd2;

    localparam logic REQ_SCHEDULE = 1'b0;

    typedef struct packed {
        logic [31:0] expiry;
        logic [7:0]  tid;
    } eotq_entry_t;

endpackage

[hw/rtl/eotq_mem.sv]
// Entry store of the timer queue: one write port, one registered read port.
// Depends on eotq_pkg.
module eotq_mem
    import eotq_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF,
    parameter int IW    = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [IW-1:0]     waddr,
    input  eotq_entry_t       wdata,
    input  logic [IW-1:0]     raddr,
    output eotq_entry_t       rdata
);

    eotq_entry_t mem [DEPTH];
    eotq_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/expiry_ordered_timer_queue_unit.sv]
// Timer queue ordered by expiry; entries held compacted in arrival order.
// Schedule: accepted in the cycle that start is seen, result strobed the next cycle, busy stays low.
// Tick: each release costs one scan of the occupied entries plus a shift of the
// later entries down by one slot; the registered memory read port paces both.
// Up to 16 releases per tick; a tick that finds nothing ends after one scan.
// Reset (async, active low) empties the queue; the entry memory is not cleared.
module expiry_ordered_timer_queue_unit
    import eotq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        req_type,
    input  logic [31:0] now_ms,
    input  logic [15:0] delay_ms,
    input  logic [7:0]  task_id,
    output logic        done,
    output logic [1:0]  status,
    output logic [7:0]  out_task,
    output logic [31:0] expiry_ms,
    output logic        last
);

`include "expiry_ordered_timer_queue_unit_defines.svh"

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_SHIFT = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     occ_reg, occ_next;
    logic [CW-1:0]     iss_reg, iss_next;
    logic              rv_reg, rv_next;
    logic [IW-1:0]     rslot_reg, rslot_next;
    logic              found_reg, found_next;
    eotq_entry_t       best_reg, best_next;
    logic [IW-1:0]     bslot_reg, bslot_next;
    eotq_entry_t       pend_reg, pend_next;
    logic              pvld_reg, pvld_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [31:0]       now_reg, now_next;
    logic              done_reg, done_next;
    logic [1:0]        status_reg, status_next;
    logic [7:0]        task_reg, task_next;
    logic [31:0]       exp_reg, exp_next;
    logic              last_reg, last_next;

    logic              mem_we;
    logic [IW-1:0]     mem_waddr;
    eotq_entry_t       mem_wdata;
    eotq_entry_t       mem_rdata;
    logic [32:0]       sum;
    logic [31:0]       sat_exp;

    eotq_mem #(.DEPTH(QUEUE_DEPTH), .IW(IW)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (iss_reg[IW-1:0]),
        .rdata (mem_rdata)
    );

    assign sum     = {1'b0, now_ms} + {17'd0, delay_ms};
    assign sat_exp = sum[32] ? 32'hFFFF_FFFF : sum[31:0];

    always_comb
    begin
        state_next  = state_reg;
        occ_next    = occ_reg;
        iss_next    = iss_reg;
        rv_next     = 1'b0;
        rslot_next  = rslot_reg;
        found_next  = found_reg;
        best_next   = best_reg;
        bslot_next  = bslot_reg;
        pend_next   = pend_reg;
        pvld_next   = pvld_reg;
        cnt_next    = cnt_reg;
        now_next    = now_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        task_next   = task_reg;
        exp_next    = exp_reg;
        last_next   = last_reg;
        mem_we      = 1'b0;
        mem_waddr   = occ_reg[IW-1:0];
        mem_wdata   = '{expiry: sat_exp, tid: task_id};

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (req_type == REQ_SCHEDULE)
                    begin
                        done_next = 1'b1;
                        task_next = task_id;
                        exp_next  = sat_exp;
                        last_next = 1'b1;
                        if (occ_reg < CW'(QUEUE_DEPTH))
                        begin
                            mem_we      = 1'b1;
                            occ_next    = occ_reg + 1'b1;
                            status_next = ST_ACCEPTED;
                        end
                        else
                        begin
                            status_next = ST_DROPPED;
                        end
                    end
                    else
                    begin
                        now_next   = now_ms;
                        cnt_next   = '0;
                        pvld_next  = 1'b0;
                        found_next = 1'b0;
                        iss_next   = '0;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (iss_reg < occ_reg)
                begin
                    rv_next    = 1'b1;
                    rslot_next = iss_reg[IW-1:0];
                    iss_next   = iss_reg + 1'b1;
                end
                // strict compare keeps the lowest slot on equal expiries
                if (rv_reg && mem_rdata.expiry < now_reg &&
                    (!found_reg || mem_rdata.expiry < best_reg.expiry))
                begin
                    found_next = 1'b1;
                    best_next  = mem_rdata;
                    bslot_next = rslot_reg;
                end
                if (iss_reg == occ_reg && !rv_reg)
                begin
                    if (pvld_reg)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_RELEASED;
                        task_next   = pend_reg.tid;
                        exp_next    = pend_reg.expiry;
                        last_next   = !found_reg;
                    end
                    if (found_reg)
                    begin
                        pend_next  = best_reg;
                        pvld_next  = 1'b1;
                        cnt_next   = cnt_reg + 1'b1;
                        iss_next   = CW'(bslot_reg) + 1'b1;
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_SHIFT:
            begin
                if (iss_reg < occ_reg)
                begin
                    rv_next    = 1'b1;
                    rslot_next = iss_reg[IW-1:0];
                    iss_next   = iss_reg + 1'b1;
                end
                if (rv_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = rslot_reg - 1'b1;
                    mem_wdata = mem_rdata;
                end
                if (iss_reg >= occ_reg && !rv_reg)
                begin
                    occ_next = occ_reg - 1'b1;
                    if (cnt_reg == CNT_W'(MAX_RESULTS))
                    begin
                        done_next   = 1'b1;
                        status_next = ST_RELEASED;
                        task_next   = pend_reg.tid;
                        exp_next    = pend_reg.expiry;
                        last_next   = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        found_next = 1'b0;
                        iss_next   = '0;
                        state_next = S_SCAN;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            occ_reg   <= '0;
            iss_reg   <= '0;
            rv_reg    <= 1'b0;
            found_reg <= 1'b0;
            pvld_reg  <= 1'b0;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            iss_reg   <= iss_next;
            rv_reg    <= rv_next;
            found_reg <= found_next;
            pvld_reg  <= pvld_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rslot_reg  <= rslot_next;
        best_reg   <= best_next;
        bslot_reg  <= bslot_next;
        pend_reg   <= pend_next;
        now_reg    <= now_next;
        status_reg <= status_next;
        task_reg   <= task_next;
        exp_reg    <= exp_next;
        last_reg   <= last_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign status    = status_reg;
    assign out_task  = task_reg;
    assign expiry_ms = exp_reg;
    assign last      = last_reg;

    `EOTQ_NEVER(a_occ_bound, occ_reg > CW'(QUEUE_DEPTH))
    `EOTQ_CHECK(a_rel_expired, (done && status == ST_RELEASED) |-> (expiry_ms < now_reg))
    `EOTQ_NEVER(a_cnt_bound, cnt_reg > CNT_W'(MAX_RESULTS))

endmodule

[tb/tb.sv]
// Self-checking testbench for expiry_ordered_timer_queue_unit.
// Depends on eotq_pkg and the unit RTL; predicts schedule and tick results.
`timescale 1ns / 100ps

module tb;
    import eotq_pkg::*;

    localparam logic REQ_TICK   = ~REQ_SCHEDULE;
    localparam int   DEPTH      = QUEUE_DEPTH_DEF;
    localparam int   WDOG_LIMIT = 5000;
    localparam int   DRAIN      = 60;

    typedef struct {
        logic [1:0]  status;
        logic [7:0]  tid;
        logic [31:0] expiry;
        logic        last;
    } timer_result_t;

    class timer_queue_scoreboard;
        logic [31:0]   held_expiry[DEPTH];
        logic [7:0]    held_task[DEPTH];
        int            held_cnt;
        timer_result_t pending[$];
        int            mismatches;

        function new();
            held_cnt   = 0;
            mismatches = 0;
        endfunction

        function void note_request(logic req, logic [31:0] now, logic [15:0] dly,
                                   logic [7:0] tid);
            timer_result_t r;
            logic [32:0]   sum;
            int            best;
            int            released;
            if (req == REQ_SCHEDULE)
            begin
                sum      = {1'b0, now} + {17'd0, dly};
                r.expiry = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                r.tid    = tid;
                r.last   = 1'b1;
                if (held_cnt >= DEPTH)
                begin
                    r.status = ST_DROPPED;
                end
                else
                begin
                    r.status = ST_ACCEPTED;
                    held_expiry[held_cnt] = r.expiry;
                    held_task[held_cnt]   = tid;
                    held_cnt++;
                end
                pending.push_back(r);
            end
            else
            begin
                released = 0;
                while (released < MAX_RESULTS)
                begin
                    best = -1;
                    // strict compare keeps the earliest arrival on equal expiry
                    for (int i = 0; i < held_cnt; i++)
                        if (held_expiry[i] < now &&
                            (best < 0 || held_expiry[i] < held_expiry[best]))
                            best = i;
                    if (best < 0)
                        break;
                    r.status = ST_RELEASED;
                    r.tid    = held_task[best];
                    r.expiry = held_expiry[best];
                    r.last   = 1'b0;
                    pending.push_back(r);
                    for (int i = best; i < held_cnt - 1; i++)
                    begin
                        held_expiry[i] = held_expiry[i + 1];
                        held_task[i]   = held_task[i + 1];
                    end
                    held_cnt--;
                    released++;
                end
                if (released > 0)
                    pending[pending.size() - 1].last = 1'b1;
            end
        endfunction

        function void check_result(logic [1:0] st, logic [7:0] tid, logic [31:0] exp_ms,
                                   logic lst);
            timer_result_t e;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result status=%0d task=%0d expiry=%h last=%0d",
                             st, tid, exp_ms, lst);
                return;
            end
            e = pending.pop_front();
            if (st !== e.status || tid !== e.tid || exp_ms !== e.expiry || lst !== e.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"ERROR: result mismatch exp st=%0d task=%0d expiry=%h last=%0d,",
                              " got st=%0d task=%0d expiry=%h last=%0d"},
                             e.status, e.tid, e.expiry, e.last, st, tid, exp_ms, lst);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        req_type;
    logic [31:0] now_ms;
    logic [15:0] delay_ms;
    logic [7:0]  task_id;
    logic        done;
    logic [1:0]  status;
    logic [7:0]  out_task;
    logic [31:0] expiry_ms;
    logic        last;

    timer_queue_scoreboard sb;
    int          idle_pct;
    int          stalled = 0;
    logic [31:0] clock_ms;

    expiry_ordered_timer_queue_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req_type  (req_type),
        .now_ms    (now_ms),
        .delay_ms  (delay_ms),
        .task_id   (task_id),
        .done      (done),
        .status    (status),
        .out_task  (out_task),
        .expiry_ms (expiry_ms),
        .last      (last)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // result check and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_result(status, out_task, expiry_ms, last);
            if ((start && !busy) || done)
                stalled = 0;
            else
                stalled++;
            if (stalled >= WDOG_LIMIT)
            begin
                $display("expiry_ordered_timer_queue_unit regression: fail");
                $finish;
            end
        end
    end

    // called at a rising edge; returns at the edge where the request was taken
    task automatic send_request(logic req, logic [31:0] now, logic [15:0] dly,
                                logic [7:0] tid);
        // idle with idle_pct chance per cycle, drawn anew until a draw misses
        while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start    <= 1'b1;
        req_type <= req;
        now_ms   <= now;
        delay_ms <= dly;
        task_id  <= tid;
        do
            @(posedge clk);
        while (busy);
        sb.note_request(req, now, dly, tid);
    endtask

    task automatic wait_quiet();
        start <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic random_requests(int count);
        int pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                send_request(REQ_SCHEDULE, clock_ms, 16'($urandom_range(0, 300)),
                             8'($urandom_range(0, 255)));
                clock_ms += $urandom_range(0, 20);
            end
            else if (pick < 85)
            begin
                send_request(REQ_TICK, clock_ms, 16'($urandom), 8'($urandom_range(0, 255)));
                clock_ms += $urandom_range(0, 50);
            end
            else if (pick < 93)
            begin
                send_request(REQ_SCHEDULE, $urandom, 16'($urandom),
                             8'($urandom_range(0, 255)));
            end
            else
            begin
                send_request(REQ_TICK, ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom,
                             16'($urandom), 8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial
    begin
        sb       = new();
        idle_pct = 0;
        clock_ms = 32'd5000;
        rst_n    = 1'b0;
        start    = 1'b0;
        req_type = REQ_SCHEDULE;
        now_ms   = '0;
        delay_ms = '0;
        task_id  = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty queue tick, then fill with ties and overflow
        send_request(REQ_TICK, 32'd0, 16'hFFFF, 8'd0);
        for (int i = 0; i < DEPTH; i++)
            send_request(REQ_SCHEDULE, 32'd1000, (i % 3 == 0) ? 16'd0 : 16'd5, i[7:0]);
        send_request(REQ_SCHEDULE, 32'h0000_0000, 16'd0, 8'd255);
        send_request(REQ_TICK, 32'd1003, 16'd0, 8'd255);
        send_request(REQ_TICK, 32'hFFFF_FFFF, 16'd0, 8'd0);
        // saturated expiry stays held forever
        send_request(REQ_SCHEDULE, 32'hFFFF_FFF0, 16'hFFFF, 8'd255);
        send_request(REQ_TICK, 32'hFFFF_FFFF, 16'hFFFF, 8'd0);
        wait_quiet();

        idle_pct = 10;
        random_requests(70);
        wait_quiet();
        idle_pct = 73;
        random_requests(65);
        wait_quiet();
        idle_pct = 0;
        random_requests(65);
        wait_quiet();

        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("expiry_ordered_timer_queue_unit regression: pass");
        else
            $display("expiry_ordered_timer_queue_unit regression: fail");
        $finish;
    end
endmodule

[expiry_ordered_timer_queue_unit.f]
+incdir+hw/rtl
hw/rtl/eotq_pkg.sv
hw/rtl/eotq_mem.sv
hw/rtl/expiry_ordered_timer_queue_unit.sv
tb/tb.sv
